// File: hw/rtl/atan2_polynomial_approx_top_macros.svh
// assertion macros for the atan2 pipeline
// no dependencies
`ifndef ATAN2_POLYNOMIAL_APPROX_TOP_MACROS_SVH
`define ATAN2_POLYNOMIAL_APPROX_TOP_MACROS_SVH
`define AP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define AP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hw/rtl/atan2_pkg.sv
// constants and types for the atan2 pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package atan2_pkg;
  localparam int unsigned SampleWidthDefault = 16;
  localparam int unsigned RadWidth = 16;
  localparam int unsigned MdegWidth = 19;
  localparam int unsigned QBits = 15;
  localparam int unsigned AWidth = QBits + 1;
  localparam logic [15:0] Pi4Q15 = 16'd25736;
  localparam logic [13:0] CaQ15 = 14'd8018;
  localparam logic [11:0] CbQ15 = 12'd2173;
  localparam logic [33:0] HalfPiQ30 = 34'd1686629713;
  localparam logic [33:0] PiQ30 = 34'd3373259426;
  localparam logic [31:0] MdegKQ16 = 32'd3754936206;
  localparam logic [15:0] RadMax = 16'd25736;
  localparam logic [17:0] MdegMax = 18'd180000;
  localparam logic [1:0] QuadPP = 2'd0;
  localparam logic [1:0] QuadNP = 2'd1;
  localparam logic [1:0] QuadNN = 2'd2;
  localparam logic [1:0] QuadPN = 2'd3;
  typedef struct packed {
    logic       zero;
    logic       swap;
    logic       flip;
    logic [1:0] quad;
  } ctl_t;
endpackage
`default_nettype wire

// File: hw/rtl/atan2_polynomial_approx_top.sv
// Pipelined four-quadrant arctangent: one (y, x) request accepted per clock
// while the output is not stalled, through 26 register stages (independent of
// SAMPLE_WIDTH). One input stage, 16 restoring divider stages (one quotient bit of
// the Q1.15 ratio each) and nine for polynomial, octant correction and scaling.
// A stalled result freezes the whole pipeline and raises in_stall_o in the same cycle.
// Depends on atan2_pkg and the macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "atan2_polynomial_approx_top_macros.svh"
module atan2_polynomial_approx_top #(
  parameter int unsigned SAMPLE_WIDTH = atan2_pkg::SampleWidthDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] y_value_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] x_value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [atan2_pkg::RadWidth-1:0]  angle_radians_o,
  output logic signed [atan2_pkg::MdegWidth-1:0] angle_millidegrees_o
);
  import atan2_pkg::*;
  localparam int unsigned MW = SAMPLE_WIDTH + 1;
  localparam int unsigned NDiv = AWidth;
  localparam int unsigned NTail = 9;
  localparam int unsigned NStg = NDiv + 1 + NTail;

  logic adv;
  logic [NStg-1:0] vld_q;
  assign adv = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign out_valid_o = vld_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  // stage 0: magnitudes and control
  logic [MW-1:0] ay, ax;
  logic yn, xn, yle, xle, yge, xge;
  logic [1:0] quad_c;
  ctl_t ctl0;
  logic [MW-1:0] num0, den0;
  assign yn = y_value_i[SAMPLE_WIDTH-1];
  assign xn = x_value_i[SAMPLE_WIDTH-1];
  assign ay = yn ? (MW'(0) - {1'b1, y_value_i}) : {1'b0, y_value_i};
  assign ax = xn ? (MW'(0) - {1'b1, x_value_i}) : {1'b0, x_value_i};
  always_comb begin
    yge = !yn; xge = !xn;
    yle = yn || (ay == '0);
    xle = xn || (ax == '0);
    quad_c = QuadPP;
    if (yge && xle) quad_c = QuadNP;
    if (yle && xle) quad_c = QuadNN;
    if (yle && xge) quad_c = QuadPN;
    ctl0.zero = (ay == '0) && (ax == '0);
    ctl0.swap = ay > ax;
    num0 = ctl0.swap ? ax : ay;
    den0 = ctl0.swap ? ay : ax;
    ctl0.flip = (num0 != '0) && (yn != xn);
    ctl0.quad = quad_c;
  end

  // divider stages: restoring, one quotient bit each, integer bit first
  logic [MW-1:0]     rem_q [NDiv];
  logic [MW-1:0]     den_q [NDiv];
  logic [NDiv-1:0]   quo_q [NDiv+1];
  ctl_t              ctl_q [NDiv+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rem_q[0]  <= num0;
      den_q[0]  <= den0;
      quo_q[0]  <= '0;
      ctl_q[0]  <= ctl0;
    end
  end

  for (genvar g = 0; g < NDiv; g++) begin : g_div
    logic [MW:0] tr;
    logic [MW:0] df;
    // first step compares num itself, later steps shift the remainder
    assign tr = (g == 0) ? {1'b0, rem_q[g]} : {rem_q[g], 1'b0};
    assign df = tr - {1'b0, den_q[g]};
    always_ff @(posedge clk_i) begin
      if (adv) begin
        ctl_q[g+1] <= ctl_q[g];
        quo_q[g+1] <= {quo_q[g][NDiv-2:0], !df[MW]};
      end
    end
    if (g < NDiv - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (adv) begin
          den_q[g+1] <= den_q[g];
          rem_q[g+1] <= df[MW] ? tr[MW-1:0] : df[MW-1:0];
        end
      end
    end
  end

  ctl_t               c1_q;
  logic [AWidth-1:0]  a1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q <= ctl_q[NDiv];
      a1_q <= quo_q[NDiv];
    end
  end

  // tail: polynomial, octant, scaling
  logic [AWidth-1:0] a2_q;
  logic [29:0] c2_q;
  ctl_t c2c_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      c2_q  <= 30'({CaQ15, 15'd0}) + 30'(CbQ15) * 30'(a1_q);
      a2_q  <= a1_q;
      c2c_q <= c1_q;
    end
  end
  logic [31:0] ux;
  assign ux = 32'(a2_q) * (32'd32768 - 32'(a2_q));
  logic [31:0] u3_q;
  logic [29:0] c3_q;
  logic [31:0] l3_q;
  ctl_t c3_q2;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      u3_q  <= ux;
      c3_q  <= c2_q;
      l3_q  <= 32'(Pi4Q15) * 32'(a2_q);
      c3_q2 <= c2c_q;
    end
  end
  logic [61:0] p4_q;
  logic [31:0] l4_q;
  ctl_t c4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p4_q <= 62'(u3_q) * 62'(c3_q);
      l4_q <= l3_q;
      c4_q <= c3_q2;
    end
  end
  logic signed [35:0] z5_q;
  ctl_t c5_q;
  logic [33:0] f5;
  assign f5 = 34'(l4_q) + 34'((p4_q + 62'd536870912) >> 30);
  always_ff @(posedge clk_i) begin
    if (adv) begin
      z5_q <= c4_q.flip ? -$signed({2'b0, f5}) : $signed({2'b0, f5});
      c5_q <= c4_q;
    end
  end
  logic signed [35:0] ang;
  always_comb begin
    if (c5_q.swap) begin
      ang = (c5_q.quad == QuadPP || c5_q.quad == QuadNP)
          ? ($signed({2'b0, HalfPiQ30}) - z5_q) : (-$signed({2'b0, HalfPiQ30}) - z5_q);
    end else if (c5_q.quad == QuadNP) begin
      ang = $signed({2'b0, PiQ30}) + z5_q;
    end else if (c5_q.quad == QuadNN) begin
      ang = -$signed({2'b0, PiQ30}) + z5_q;
    end else begin
      ang = z5_q;
    end
    if (c5_q.zero) ang = '0;
  end
  logic        n6_q;
  logic [33:0] m6_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      n6_q <= ang[35];
      m6_q <= ang[35] ? 34'(-ang) : 34'(ang);
    end
  end
  logic        n7_q;
  logic [17:0] r7_q;
  logic [33:0] m7l_q;
  logic [33:0] m7h_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      n7_q  <= n6_q;
      r7_q  <= 18'((m6_q + 34'd65536) >> 17);
      m7l_q <= m6_q;
      m7h_q <= m6_q;
    end
  end
  logic [65:0] pl8_q, ph8_q;
  logic        n8_q;
  logic [17:0] r8_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pl8_q <= 66'(m7l_q[16:0]) * 66'(MdegKQ16);
      ph8_q <= 66'(m7h_q[33:17]) * 66'(MdegKQ16);
      n8_q  <= n7_q;
      r8_q  <= r7_q;
    end
  end
  logic [65:0] md_full;
  logic [19:0] md;
  assign md_full = (ph8_q << 17) + pl8_q + (66'd1 << 45);
  assign md = 20'(md_full >> 46);
  logic [15:0] rs;
  logic [17:0] ms;
  assign rs = (r8_q > 18'(RadMax)) ? RadMax : r8_q[15:0];
  assign ms = (md > 20'(MdegMax)) ? MdegMax : md[17:0];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      angle_radians_o      <= n8_q ? -$signed(rs) : $signed(rs);
      angle_millidegrees_o <= n8_q ? -$signed({1'b0, ms}) : $signed({1'b0, ms});
    end
  end

  `AP_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
      out_valid_o && $stable(angle_radians_o), "held result changed")
  `AP_ASSERT_IMPL(a_rad_rng, clk_i, rst_ni, out_valid_o,
      angle_radians_o <= $signed(RadMax) && angle_radians_o >= -$signed(RadMax),
      "radians out of range")
  `AP_ASSERT_IMPL(a_stall_eq, clk_i, rst_ni, 1'b1,
      in_stall_o == (out_valid_o && out_stall_i), "stall mismatch")
endmodule
`default_nettype wire
